### rtl/button_gesture_classifier_core_defines.svh
// Assertion macros for the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BGC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bgc check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define BGC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bgc check failed: next-cycle implication");

`endif

### rtl/bgc_pkg.sv
// Types, codes and reset values for the button gesture classifier.
package bgc_pkg;

   localparam int CFG_WIDTH       = 16;
   localparam int CFG_INDEX_WIDTH = 3;
   localparam int EDGE_WIDTH      = 2;
   localparam int EVENT_WIDTH     = 3;
   localparam int MODE_WIDTH      = 3;

   typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_type;
   typedef logic [CFG_WIDTH-1:0]       cfg_word_type;
   typedef logic [EDGE_WIDTH-1:0]      edge_type;
   typedef logic [EVENT_WIDTH-1:0]     event_type;
   typedef logic [MODE_WIDTH-1:0]      mode_code_type;

   localparam cfg_index_type CFG_CLICK_MIN     = 3'd0;
   localparam cfg_index_type CFG_CLICK_MAX     = 3'd1;
   localparam cfg_index_type CFG_LONG_MIN      = 3'd2;
   localparam cfg_index_type CFG_LONG_MAX      = 3'd3;
   localparam cfg_index_type CFG_VERY_LONG_MIN = 3'd4;
   localparam cfg_index_type CFG_VERY_LONG_MAX = 3'd5;
   localparam cfg_index_type CFG_DROP_LIMIT    = 3'd6;
   localparam cfg_index_type CFG_DOUBLE_GAP    = 3'd7;

   localparam cfg_word_type RST_CLICK_MIN     = 16'd20;
   localparam cfg_word_type RST_CLICK_MAX     = 16'd500;
   localparam cfg_word_type RST_LONG_MIN      = 16'd501;
   localparam cfg_word_type RST_LONG_MAX      = 16'd2000;
   localparam cfg_word_type RST_VERY_LONG_MIN = 16'd2001;
   localparam cfg_word_type RST_VERY_LONG_MAX = 16'd5000;
   localparam cfg_word_type RST_DROP_LIMIT    = 16'd5001;
   localparam cfg_word_type RST_DOUBLE_GAP    = 16'd300;

   localparam edge_type EDGE_RISE = 2'd1;
   localparam edge_type EDGE_FALL = 2'd2;

   localparam event_type EV_NONE   = 3'd0;
   localparam event_type EV_CLICK  = 3'd1;
   localparam event_type EV_DOUBLE = 3'd2;
   localparam event_type EV_LONG   = 3'd3;
   localparam event_type EV_VLONG  = 3'd4;

   localparam mode_code_type MODE_CODE_IDLE     = 3'd0;
   localparam mode_code_type MODE_CODE_PRESSED  = 3'd1;
   localparam mode_code_type MODE_CODE_RELEASED = 3'd2;
   localparam mode_code_type MODE_CODE_IDENT    = 3'd3;
   localparam mode_code_type MODE_CODE_CLICK    = 3'd4;
   localparam mode_code_type MODE_CODE_DOUBLE   = 3'd5;
   localparam mode_code_type MODE_CODE_LONG     = 3'd6;
   localparam mode_code_type MODE_CODE_VLONG    = 3'd7;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PRESSED  = 8'b0000_0010,
      ST_RELEASED = 8'b0000_0100,
      ST_IDENT    = 8'b0000_1000,
      ST_CLICK    = 8'b0001_0000,
      ST_DOUBLE   = 8'b0010_0000,
      ST_LONG     = 8'b0100_0000,
      ST_VLONG    = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      cfg_word_type click_min;
      cfg_word_type click_max;
      cfg_word_type long_min;
      cfg_word_type long_max;
      cfg_word_type very_long_min;
      cfg_word_type very_long_max;
      cfg_word_type drop_limit;
      cfg_word_type double_gap;
   } cfg_type;

   function automatic mode_code_type mode_code(input mode_type mode);
      mode_code_type code;
      case (mode)
         ST_IDLE:     code = MODE_CODE_IDLE;
         ST_PRESSED:  code = MODE_CODE_PRESSED;
         ST_RELEASED: code = MODE_CODE_RELEASED;
         ST_IDENT:    code = MODE_CODE_IDENT;
         ST_CLICK:    code = MODE_CODE_CLICK;
         ST_DOUBLE:   code = MODE_CODE_DOUBLE;
         ST_LONG:     code = MODE_CODE_LONG;
         ST_VLONG:    code = MODE_CODE_VLONG;
         default:     code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

### rtl/bgc_csr.sv
// Configuration register file for the hold and gap windows.
module bgc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bgc_pkg::cfg_index_type csr_index,
   input  bgc_pkg::cfg_word_type  csr_wdata,
   output bgc_pkg::cfg_type       cfg
);
   import bgc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_CLICK_MIN:     cfg_in.click_min     = csr_wdata;
            CFG_CLICK_MAX:     cfg_in.click_max     = csr_wdata;
            CFG_LONG_MIN:      cfg_in.long_min      = csr_wdata;
            CFG_LONG_MAX:      cfg_in.long_max      = csr_wdata;
            CFG_VERY_LONG_MIN: cfg_in.very_long_min = csr_wdata;
            CFG_VERY_LONG_MAX: cfg_in.very_long_max = csr_wdata;
            CFG_DROP_LIMIT:    cfg_in.drop_limit    = csr_wdata;
            CFG_DOUBLE_GAP:    cfg_in.double_gap    = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_min     <= RST_CLICK_MIN;
         cfg_ff.click_max     <= RST_CLICK_MAX;
         cfg_ff.long_min      <= RST_LONG_MIN;
         cfg_ff.long_max      <= RST_LONG_MAX;
         cfg_ff.very_long_min <= RST_VERY_LONG_MIN;
         cfg_ff.very_long_max <= RST_VERY_LONG_MAX;
         cfg_ff.drop_limit    <= RST_DROP_LIMIT;
         cfg_ff.double_gap    <= RST_DOUBLE_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/bgc_fsm.sv
// Gesture state machine, tick counter, time stamps and result register.
`include "button_gesture_classifier_core_defines.svh"

module bgc_fsm #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bgc_pkg::cfg_type       cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bgc_pkg::edge_type      req_edge_req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bgc_pkg::event_type     rsp_event_res,
   output bgc_pkg::mode_code_type rsp_mode_now
);
   import bgc_pkg::*;

   mode_type              mode_ff;
   mode_type              mode_in;
   mode_type              mode_eff;
   logic [TICK_WIDTH-1:0] tick_ff;
   logic [TICK_WIDTH-1:0] tick_in;
   logic [TICK_WIDTH-1:0] press_ff;
   logic [TICK_WIDTH-1:0] press_in;
   logic [TICK_WIDTH-1:0] last_ff;
   logic [TICK_WIDTH-1:0] last_in;
   logic [TICK_WIDTH-1:0] hold;
   logic [TICK_WIDTH-1:0] gap;
   event_type             event_in;
   event_type             event_ff;
   mode_code_type         code_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  accept;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = event_ff;
   assign rsp_mode_now  = code_ff;
   assign rsp_valid_in  = accept || (rsp_valid_ff && !rsp_ready);

   assign hold    = tick_ff - press_ff;
   assign gap     = tick_ff - last_ff;
   assign tick_in = tick_ff + TICK_WIDTH'(1);

   always_comb begin
      if (req_edge_req == EDGE_RISE) begin
         mode_eff = ST_PRESSED;
      end else if (req_edge_req == EDGE_FALL) begin
         mode_eff = ST_RELEASED;
      end else begin
         mode_eff = mode_ff;
      end
   end

   always_comb begin
      mode_in  = ST_IDLE;
      press_in = press_ff;
      last_in  = last_ff;
      event_in = EV_NONE;
      case (mode_eff)
         ST_PRESSED: begin
            press_in = tick_ff;
         end
         ST_RELEASED: begin
            if (hold >= TICK_WIDTH'(cfg.click_min) && hold <= TICK_WIDTH'(cfg.click_max)) begin
               mode_in = ST_IDENT;
            end else if (hold >= TICK_WIDTH'(cfg.long_min)
                         && hold <= TICK_WIDTH'(cfg.long_max)) begin
               mode_in = ST_LONG;
            end else if (hold >= TICK_WIDTH'(cfg.very_long_min)
                         && hold <= TICK_WIDTH'(cfg.very_long_max)) begin
               mode_in = ST_VLONG;
            end else if (hold >= TICK_WIDTH'(cfg.drop_limit)) begin
               mode_in = ST_IDLE;
            end else begin
               mode_in = ST_RELEASED;
            end
         end
         ST_IDENT: begin
            if (gap > TICK_WIDTH'(cfg.double_gap)) begin
               last_in = tick_ff;
               mode_in = ST_CLICK;
            end else begin
               mode_in = ST_DOUBLE;
            end
         end
         ST_CLICK:  event_in = EV_CLICK;
         ST_DOUBLE: event_in = EV_DOUBLE;
         ST_LONG:   event_in = EV_LONG;
         ST_VLONG:  event_in = EV_VLONG;
         default:   mode_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ST_IDLE;
         tick_ff      <= '0;
         press_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff  <= mode_in;
            tick_ff  <= tick_in;
            press_ff <= press_in;
            last_ff  <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_in;
         code_ff  <= mode_code(mode_in);
      end
   end

   `BGC_ASSERT_NOW(a_event_ends_idle, rsp_valid_ff && event_ff != EV_NONE, code_ff == MODE_CODE_IDLE)
   `BGC_ASSERT_NOW(a_ready_when_empty, !rsp_valid_ff, req_ready)
   `BGC_ASSERT_NEXT(a_tick_advances, accept, tick_ff == $past(tick_ff) + TICK_WIDTH'(1))
   `BGC_ASSERT_NEXT(a_press_stamps, accept && req_edge_req == EDGE_RISE, press_ff == $past(tick_ff) && mode_ff == ST_IDLE)

endmodule

### rtl/button_gesture_classifier_core.sv
// Top level of the button gesture classifier: register file and state machine.
//
// Takes one tick beat per clock on the req_ channel unless rsp_ stalls, and returns one result
// beat per tick on the rsp_ channel: an event code (click, double click, long press, long-long
// press) and the machine mode after that tick's transition. The state machine does
// its single transition between its state registers and the result register, and the result
// shows on rsp_ the cycle after the tick is taken. req_ready is high whenever the result
// register is empty or being taken in the same cycle, so a new tick is accepted every clock
// while the consumer keeps up. Hold and gap times are tick differences modulo 2^TICK_WIDTH,
// compared against the eight 16-bit window registers written through the csr_ port.
module button_gesture_classifier_core #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bgc_pkg::cfg_index_type csr_index,
   input  bgc_pkg::cfg_word_type  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bgc_pkg::edge_type      req_edge_req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bgc_pkg::event_type     rsp_event_res,
   output bgc_pkg::mode_code_type rsp_mode_now
);
   import bgc_pkg::*;

   cfg_type cfg;

   bgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgc_fsm #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_edge_req  (req_edge_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_mode_now  (rsp_mode_now)
   );

endmodule

### dv/button_gesture_classifier_core_test.sv
// Self-checking testbench for the button gesture classifier: directed script, then random phases.
module button_gesture_classifier_core_test;
   import bgc_pkg::*;

   localparam edge_type EDGE_IDLE = 2'd0;
   localparam edge_type EDGE_JUNK = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 1950;
   localparam int PHASES         = 8;

   typedef enum int {SET_ORDERED, SET_ZERO, SET_SCATTER, SET_ONES} setting_kind;

   typedef struct {
      event_type     ev;
      mode_code_type md;
   } tick_result;

   typedef struct {
      bit            is_cfg;
      cfg_index_type idx;
      cfg_word_type  wdata;
      edge_type      edge_in;
      bit            typed;
      event_type     ev;
      mode_code_type md;
   } script_row;

   logic          clock;
   logic          reset;
   logic          csr_valid;
   logic          csr_ready;
   cfg_index_type csr_index;
   cfg_word_type  csr_wdata;
   logic          req_valid;
   logic          req_ready;
   edge_type      req_edge_req;
   logic          rsp_valid;
   logic          rsp_ready;
   event_type     rsp_event_res;
   mode_code_type rsp_mode_now;

   logic          beat_typed;
   event_type     beat_ev;
   mode_code_type beat_md;

   // gesture predictor state
   cfg_word_type  window_cfg [0:7];
   mode_code_type gm;
   logic [31:0]   tick_now;
   logic [31:0]   press_at;
   logic [31:0]   last_click_at;

   tick_result    expected_events [$];
   script_row     script [$];
   int            mismatch_count;
   int            stalled_cycles;
   int            items_sent;
   int            stall_left;
   bit            idle_on;

   button_gesture_classifier_core dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_edge_req  (req_edge_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_mode_now  (rsp_mode_now)
   );

   always #5 clock = ~clock;

   task automatic classify_tick(input edge_type e, output tick_result r);
      logic [31:0] hold;
      logic [31:0] since_click;
      r.ev = EV_NONE;
      if (e == EDGE_RISE) begin
         gm = MODE_CODE_PRESSED;
      end else if (e == EDGE_FALL) begin
         gm = MODE_CODE_RELEASED;
      end
      hold        = tick_now - press_at;
      since_click = tick_now - last_click_at;
      case (gm)
         MODE_CODE_PRESSED: begin
            press_at = tick_now;
            gm       = MODE_CODE_IDLE;
         end
         MODE_CODE_RELEASED: begin
            if (hold >= window_cfg[CFG_CLICK_MIN] && hold <= window_cfg[CFG_CLICK_MAX]) begin
               gm = MODE_CODE_IDENT;
            end else if (hold >= window_cfg[CFG_LONG_MIN] && hold <= window_cfg[CFG_LONG_MAX]) begin
               gm = MODE_CODE_LONG;
            end else if (hold >= window_cfg[CFG_VERY_LONG_MIN]
                         && hold <= window_cfg[CFG_VERY_LONG_MAX]) begin
               gm = MODE_CODE_VLONG;
            end else if (hold >= window_cfg[CFG_DROP_LIMIT]) begin
               gm = MODE_CODE_IDLE;
            end
         end
         MODE_CODE_IDENT: begin
            if (since_click > {16'd0, window_cfg[CFG_DOUBLE_GAP]}) begin
               last_click_at = tick_now;
               gm            = MODE_CODE_CLICK;
            end else begin
               gm = MODE_CODE_DOUBLE;
            end
         end
         MODE_CODE_CLICK: begin
            r.ev = EV_CLICK;
            gm   = MODE_CODE_IDLE;
         end
         MODE_CODE_DOUBLE: begin
            r.ev = EV_DOUBLE;
            gm   = MODE_CODE_IDLE;
         end
         MODE_CODE_LONG: begin
            r.ev = EV_LONG;
            gm   = MODE_CODE_IDLE;
         end
         MODE_CODE_VLONG: begin
            r.ev = EV_VLONG;
            gm   = MODE_CODE_IDLE;
         end
         default: begin
            gm = MODE_CODE_IDLE;
         end
      endcase
      tick_now = tick_now + 32'd1;
      r.md     = gm;
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   always @(posedge clock) begin
      tick_result pred;
      tick_result want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            window_cfg[csr_index] = csr_wdata;
         end
         if (req_valid && req_ready) begin
            classify_tick(req_edge_req, pred);
            if (beat_typed) begin
               want.ev = beat_ev;
               want.md = beat_md;
               expected_events.push_back(want);
            end else begin
               expected_events.push_back(pred);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               note_mismatch($sformatf("result beat with nothing pending: event %0d mode %0d",
                                       rsp_event_res, rsp_mode_now));
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_res !== want.ev || rsp_mode_now !== want.md) begin
                  note_mismatch($sformatf("result mismatch: event exp %0d got %0d, mode exp %0d got %0d",
                                          want.ev, rsp_event_res, want.md, rsp_mode_now));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver: stall in bursts while idle_on is set, else always ready
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_tick(input edge_type e, input bit typed, input event_type ev,
                            input mode_code_type md);
      if (idle_on && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_edge_req <= e;
      beat_typed   <= typed;
      beat_ev      <= ev;
      beat_md      <= md;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic tick(input edge_type e);
      send_tick(e, 1'b0, EV_NONE, MODE_CODE_IDLE);
   endtask

   task automatic csr_write(input cfg_index_type idx, input cfg_word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
   endtask

   task automatic add_tick(input edge_type e, input bit typed, input event_type ev,
                           input mode_code_type md);
      script_row row;
      row.is_cfg  = 1'b0;
      row.idx     = CFG_CLICK_MIN;
      row.wdata   = '0;
      row.edge_in = e;
      row.typed   = typed;
      row.ev      = ev;
      row.md      = md;
      script.push_back(row);
   endtask

   task automatic add_cfg(input cfg_index_type idx, input cfg_word_type data);
      script_row row;
      row.is_cfg  = 1'b1;
      row.idx     = idx;
      row.wdata   = data;
      row.edge_in = EDGE_IDLE;
      row.typed   = 1'b0;
      row.ev      = EV_NONE;
      row.md      = MODE_CODE_IDLE;
      script.push_back(row);
   endtask

   function automatic edge_type filler_edge();
      if ($urandom_range(0, 11) == 0) begin
         return edge_type'($urandom_range(0, 3));
      end
      return EDGE_IDLE;
   endfunction

   task automatic run_phase(input setting_kind kind, input int quota, input bit calm);
      cfg_word_type v [0:7];
      int hold_cap;
      int hold;
      int start_count;
      wait_drain();
      case (kind)
         SET_ZERO: begin
            foreach (v[i]) v[i] = 16'h0000;
            hold_cap = 8;
         end
         SET_ONES: begin
            foreach (v[i]) v[i] = 16'hFFFF;
            hold_cap = 8;
         end
         SET_SCATTER: begin
            foreach (v[i]) v[i] = cfg_word_type'($urandom_range(0, 24));
            hold_cap = 28;
         end
         default: begin
            v[CFG_CLICK_MIN]     = cfg_word_type'($urandom_range(0, 4));
            v[CFG_CLICK_MAX]     = v[CFG_CLICK_MIN] + cfg_word_type'($urandom_range(0, 6));
            v[CFG_LONG_MIN]      = v[CFG_CLICK_MAX] + cfg_word_type'($urandom_range(0, 3));
            v[CFG_LONG_MAX]      = v[CFG_LONG_MIN] + cfg_word_type'($urandom_range(0, 6));
            v[CFG_VERY_LONG_MIN] = v[CFG_LONG_MAX] + cfg_word_type'($urandom_range(0, 3));
            v[CFG_VERY_LONG_MAX] = v[CFG_VERY_LONG_MIN] + cfg_word_type'($urandom_range(0, 8));
            v[CFG_DROP_LIMIT]    = v[CFG_VERY_LONG_MAX] + cfg_word_type'($urandom_range(0, 4));
            v[CFG_DOUBLE_GAP]    = cfg_word_type'($urandom_range(0, 40));
            hold_cap = int'(v[CFG_DROP_LIMIT]) + 4;
         end
      endcase
      for (int i = 0; i <= CFG_DOUBLE_GAP; i++) begin
         csr_write(cfg_index_type'(i), v[i]);
      end
      csr_valid <= 1'b0;
      idle_on = !calm;
      start_count = items_sent;
      while (items_sent - start_count < quota) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) tick(edge_type'($urandom_range(0, 3)));
         end else begin
            hold = $urandom_range(1, hold_cap);
            tick(EDGE_RISE);
            repeat (hold - 1) tick(filler_edge());
            tick(EDGE_FALL);
            repeat ($urandom_range(0, 8)) tick(filler_edge());
         end
      end
   endtask

   initial begin
      setting_kind plan [PHASES];
      clock          = 1'b0;
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_index      = CFG_CLICK_MIN;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_edge_req   = EDGE_IDLE;
      rsp_ready      = 1'b0;
      beat_typed     = 1'b0;
      beat_ev        = EV_NONE;
      beat_md        = MODE_CODE_IDLE;
      mismatch_count = 0;
      stalled_cycles = 0;
      items_sent     = 0;
      stall_left     = 0;
      idle_on        = 1'b1;
      gm             = MODE_CODE_IDLE;
      tick_now       = '0;
      press_at       = '0;
      last_click_at  = '0;
      window_cfg[CFG_CLICK_MIN]     = RST_CLICK_MIN;
      window_cfg[CFG_CLICK_MAX]     = RST_CLICK_MAX;
      window_cfg[CFG_LONG_MIN]      = RST_LONG_MIN;
      window_cfg[CFG_LONG_MAX]      = RST_LONG_MAX;
      window_cfg[CFG_VERY_LONG_MIN] = RST_VERY_LONG_MIN;
      window_cfg[CFG_VERY_LONG_MAX] = RST_VERY_LONG_MAX;
      window_cfg[CFG_DROP_LIMIT]    = RST_DROP_LIMIT;
      window_cfg[CFG_DOUBLE_GAP]    = RST_DOUBLE_GAP;

      // reset windows: junk edge, short hold left pending, edge overriding released
      add_tick(EDGE_IDLE, 1'b1, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_JUNK, 1'b1, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_RISE, 1'b1, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_FALL, 1'b1, EV_NONE, MODE_CODE_RELEASED);
      add_tick(EDGE_RISE, 1'b1, EV_NONE, MODE_CODE_IDLE);
      // one-tick windows with a gap before drop
      add_cfg(CFG_CLICK_MIN, 16'd1);
      add_cfg(CFG_CLICK_MAX, 16'd1);
      add_cfg(CFG_LONG_MIN, 16'd2);
      add_cfg(CFG_LONG_MAX, 16'd2);
      add_cfg(CFG_VERY_LONG_MIN, 16'd3);
      add_cfg(CFG_VERY_LONG_MAX, 16'd3);
      add_cfg(CFG_DROP_LIMIT, 16'd5);
      // early first click turns into a double click
      add_tick(EDGE_FALL, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      // long press
      add_tick(EDGE_RISE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_FALL, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      // long-long press
      add_tick(EDGE_RISE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_FALL, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      // hold in the gap, then dropped
      add_tick(EDGE_RISE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_FALL, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_IDLE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      // press lands mid-classification, click lost
      add_tick(EDGE_RISE, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_FALL, 1'b0, EV_NONE, MODE_CODE_IDLE);
      add_tick(EDGE_RISE, 1'b0, EV_NONE, MODE_CODE_IDLE);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            if (!csr_valid) begin
               wait_drain();
            end
            csr_write(script[i].idx, script[i].wdata);
         end else begin
            if (csr_valid) begin
               csr_valid <= 1'b0;
            end
            send_tick(script[i].edge_in, script[i].typed, script[i].ev, script[i].md);
         end
      end

      plan = '{SET_ORDERED, SET_ZERO, SET_SCATTER, SET_ORDERED,
               SET_ONES, SET_SCATTER, SET_ORDERED, SET_ORDERED};
      for (int p = 0; p < PHASES; p++) begin
         run_phase(plan[p], RANDOM_ITEMS / PHASES,
                   (p == PHASES - 1) || ($urandom_range(0, 4) == 0));
      end

      wait_drain();
      repeat (4) @(negedge clock);
      if (expected_events.size() != 0) begin
         note_mismatch($sformatf("%0d expected results never arrived", expected_events.size()));
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
